// ----- rtl/core/mlie_pkg.sv -----
`timescale 1ns / 1ps
package mlie_pkg;

   typedef enum logic [4:0] {
      OP_ADD  = 5'd0,  OP_ADDI = 5'd1,  OP_SUB  = 5'd2,  OP_SUBI = 5'd3,
      OP_MUL  = 5'd4,  OP_MULI = 5'd5,  OP_OR   = 5'd6,  OP_ORI  = 5'd7,
      OP_AND  = 5'd8,  OP_ANDI = 5'd9,  OP_XOR  = 5'd10, OP_XORI = 5'd11,
      OP_LDW  = 5'd12, OP_STW  = 5'd13, OP_BZ   = 5'd14, OP_BEQ  = 5'd15,
      OP_JR   = 5'd16, OP_HALT = 5'd17
   } opcode_type;

   localparam logic [31:0] PC_STEP = 32'd4;

   // decoded beat passed from front to back
   typedef struct packed {
      logic [4:0]  action;
      logic [4:0]  src_reg;
      logic [4:0]  second_reg;
      logic [4:0]  dest_reg;
      logic [31:0] imm;
      logic        bad_op;
   } decoded_type;

   // one result beat
   typedef struct packed {
      logic [31:0] next_pc;
      logic        halted;
      logic        reg_write_valid;
      logic [4:0]  reg_write_index;
      logic [31:0] reg_write_value;
      logic        mem_write_valid;
      logic [9:0]  mem_word_index;
      logic [31:0] mem_write_value;
      logic        invalid_opcode;
      logic        address_error;
   } result_type;

endpackage

// ----- rtl/core/mips_lite_instruction_executor_core.sv -----
`timescale 1ns / 1ps
// An accepted instruction reaches the result ports through the input queue,
// then one operand/address stage, then the result queue.
// Throughput: one instruction per cycle unless the memory clear or full queues stall it.
// Reset: synchronous, active high; pc, halt flag and register file read as zero
// (valid bit per register), queues empty. The data memory is then zeroed one word
// per cycle; the input holds full once two beats wait.
module mips_lite_instruction_executor_core
   import mlie_pkg::*;
#(
   parameter int MEM_WORDS = 1024,
   parameter int REG_COUNT = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               full,
   input  logic [4:0]         req_action,
   input  logic [4:0]         req_src_reg,
   input  logic [4:0]         req_second_reg,
   input  logic [4:0]         req_dest_reg,
   input  logic signed [15:0] req_immediate,
   output logic               empty,
   input  logic               pop,
   output logic [31:0]        rsp_next_pc,
   output logic               rsp_halted,
   output logic               rsp_reg_write_valid,
   output logic [4:0]         rsp_reg_write_index,
   output logic signed [31:0] rsp_reg_write_value,
   output logic               rsp_mem_write_valid,
   output logic [9:0]         rsp_mem_word_index,
   output logic signed [31:0] rsp_mem_write_value,
   output logic               rsp_invalid_opcode,
   output logic               rsp_address_error
);
   logic        dq_valid, dq_take, res_valid;
   decoded_type dq_data;
   result_type  res_data;

   mlie_front #(.REG_COUNT(REG_COUNT)) u_front (
      .clock, .reset, .req_push, .req_full(full),
      .req_action, .req_src_reg, .req_second_reg, .req_dest_reg, .req_immediate,
      .dq_valid, .dq_data, .dq_take
   );

   mlie_back #(.MEM_WORDS(MEM_WORDS), .REG_COUNT(REG_COUNT)) u_back (
      .clock, .reset, .dq_valid, .dq_data, .dq_take,
      .res_valid, .res_data, .res_take(pop)
   );

   // present the oldest result beat
   assign empty               = !res_valid;
   assign rsp_next_pc         = res_data.next_pc;
   assign rsp_halted          = res_data.halted;
   assign rsp_reg_write_valid = res_data.reg_write_valid;
   assign rsp_reg_write_index = res_data.reg_write_index;
   assign rsp_reg_write_value = res_data.reg_write_value;
   assign rsp_mem_write_valid = res_data.mem_write_valid;
   assign rsp_mem_word_index  = res_data.mem_word_index;
   assign rsp_mem_write_value = res_data.mem_write_value;
   assign rsp_invalid_opcode  = res_data.invalid_opcode;
   assign rsp_address_error   = res_data.address_error;
endmodule

// ----- rtl/core/mlie_ram.sv -----
`timescale 1ns / 1ps
module mlie_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

// ----- rtl/core/mlie_front.sv -----
`timescale 1ns / 1ps
module mlie_front
   import mlie_pkg::*;
#(
   parameter int REG_COUNT = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic [4:0]        req_action,
   input  logic [4:0]        req_src_reg,
   input  logic [4:0]        req_second_reg,
   input  logic [4:0]        req_dest_reg,
   input  logic signed [15:0] req_immediate,
   output logic              dq_valid,
   output decoded_type       dq_data,
   input  logic              dq_take
);
   localparam int DEPTH = 2;
   decoded_type buf_ff [DEPTH];
   logic [0:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   decoded_type dec;
   logic push_ok, pop_ok;

   // a 5-bit index is below four times REG_COUNT, so three subtracts suffice
   function automatic logic [4:0] reduce(input logic [4:0] idx);
      logic [5:0] r;
      r = {1'b0, idx};
      for (int i = 0; i < 3; i++) begin
         if (r >= 6'(REG_COUNT)) r = r - 6'(REG_COUNT);
      end
      reduce = r[4:0];
   endfunction

   // classify the opcode, reduce register indexes and sign-extend the immediate
   always_comb begin
      dec.action     = req_action;
      dec.src_reg    = reduce(req_src_reg);
      dec.second_reg = reduce(req_second_reg);
      dec.dest_reg   = reduce(req_dest_reg);
      dec.imm        = {{16{req_immediate[15]}}, req_immediate};
      dec.bad_op     = (req_action > OP_HALT);
   end

   assign req_full = (cnt_ff == 2'(DEPTH));
   assign push_ok  = req_push && !req_full;
   assign pop_ok   = dq_take && (cnt_ff != 2'd0);
   assign dq_valid = (cnt_ff != 2'd0);
   assign dq_data  = buf_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + 1'(push_ok);
      rd_ptr_in = rd_ptr_ff + 1'(pop_ok);
      cnt_in    = cnt_ff + 2'(push_ok) - 2'(pop_ok);
   end

   // advance queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // hold queued beats
   always_ff @(posedge clock) begin
      if (push_ok) begin
         buf_ff[wr_ptr_ff] <= dec;
      end
   end
endmodule

// ----- rtl/core/mlie_back.sv -----
`timescale 1ns / 1ps
module mlie_back
   import mlie_pkg::*;
#(
   parameter int MEM_WORDS = 1024,
   parameter int REG_COUNT = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        dq_valid,
   input  decoded_type dq_data,
   output logic        dq_take,
   output logic        res_valid,
   output result_type  res_data,
   input  logic        res_take
);
   localparam int AW = $clog2(MEM_WORDS);
   localparam int RW = $clog2(REG_COUNT);

   // register file, valid bits stand in for reset
   logic [31:0] rf_ff [REG_COUNT];
   logic [REG_COUNT-1:0] rf_vld_ff;

   // data memory clearing pass after reset
   logic          clr_busy_ff;
   logic [AW-1:0] clr_idx_ff;

   // stage 1: address / operands; stage 2: execute with ram data
   logic        s1_ff;
   decoded_type s1_d_ff;
   logic [31:0] s1_a_ff, s1_b_ff, s1_prod_ff;
   logic        s1_bad_addr_ff;
   logic [AW-1:0] s1_word_ff;
   logic        s1_fwd_ff;
   logic [31:0] s1_fwd_val_ff;

   logic [31:0] pc_ff, pc_in;
   logic        halt_ff, halt_in;

   // output skid: two-entry queue
   result_type ob_ff [2];
   logic [0:0] ow_ff, or_ff;
   logic [1:0] ocnt_ff;

   logic [31:0] a_rd, b_rd, addr, ram_q;
   logic [32:0] word_full;
   logic        bad_addr, wr_rf, ram_we;
   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic [31:0]   ram_wr_data;
   logic [RW-1:0] wr_idx;
   logic [31:0]  wr_val;
   result_type   res;

   // room: at most one beat in stage 1 plus queue
   assign dq_take = dq_valid && !clr_busy_ff && ((ocnt_ff + 2'(s1_ff)) < 2'd2 ||
                    (res_take && ocnt_ff != 2'd0));

   // read operands with bypass from the finishing instruction
   always_comb begin
      a_rd = rf_vld_ff[dq_data.src_reg[RW-1:0]] ? rf_ff[dq_data.src_reg[RW-1:0]] : '0;
      b_rd = rf_vld_ff[dq_data.second_reg[RW-1:0]] ? rf_ff[dq_data.second_reg[RW-1:0]] : '0;
      if (wr_rf && wr_idx == dq_data.src_reg[RW-1:0]) a_rd = wr_val;
      if (wr_rf && wr_idx == dq_data.second_reg[RW-1:0]) b_rd = wr_val;
      addr      = a_rd + dq_data.imm;
      word_full = {3'b0, addr[31:2]};
      bad_addr  = addr[31] || (word_full >= 33'(MEM_WORDS));
   end

   // zero the data memory one word per cycle after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_idx_ff  <= '0;
      end else if (clr_busy_ff) begin
         clr_idx_ff <= clr_idx_ff + AW'(1);
         if (clr_idx_ff == AW'(MEM_WORDS - 1)) clr_busy_ff <= 1'b0;
      end
   end

   // stage 1 registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= 1'b0;
      end else begin
         s1_ff <= dq_take;
      end
      if (dq_take) begin
         s1_d_ff        <= dq_data;
         s1_a_ff        <= a_rd;
         s1_b_ff        <= b_rd;
         s1_bad_addr_ff <= bad_addr;
         s1_word_ff     <= addr[AW+1:2];
         s1_prod_ff     <= a_rd * ((dq_data.action == OP_MULI) ? dq_data.imm : b_rd);
         // forward a store that writes the word being read this cycle
         s1_fwd_ff      <= ram_we && (s1_word_ff == addr[AW+1:2]);
         s1_fwd_val_ff  <= s1_b_ff;
      end
   end

   assign ram_we = s1_ff && s1_d_ff.action == OP_STW && !s1_bad_addr_ff;

   assign ram_wr_en   = ram_we || clr_busy_ff;
   assign ram_wr_addr = clr_busy_ff ? clr_idx_ff : s1_word_ff;
   assign ram_wr_data = clr_busy_ff ? '0 : s1_b_ff;

   mlie_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_addr(addr[AW+1:2]),
      .rd_data(ram_q)
   );

   // execute stage 1 beat
   always_comb begin
      res = '0;
      pc_in = pc_ff + PC_STEP;
      halt_in = halt_ff;
      wr_rf = 1'b0;
      wr_idx = s1_d_ff.second_reg[RW-1:0];
      wr_val = '0;
      case (s1_d_ff.action)
         OP_ADD:  begin wr_rf = 1'b1; wr_idx = s1_d_ff.dest_reg[RW-1:0]; wr_val = s1_a_ff + s1_b_ff; end
         OP_ADDI: begin wr_rf = 1'b1; wr_val = s1_a_ff + s1_d_ff.imm; end
         OP_SUB:  begin wr_rf = 1'b1; wr_idx = s1_d_ff.dest_reg[RW-1:0]; wr_val = s1_a_ff - s1_b_ff; end
         OP_SUBI: begin wr_rf = 1'b1; wr_val = s1_a_ff - s1_d_ff.imm; end
         OP_MUL:  begin wr_rf = 1'b1; wr_idx = s1_d_ff.dest_reg[RW-1:0]; wr_val = s1_prod_ff; end
         OP_MULI: begin wr_rf = 1'b1; wr_val = s1_prod_ff; end
         OP_OR:   begin wr_rf = 1'b1; wr_idx = s1_d_ff.dest_reg[RW-1:0]; wr_val = s1_a_ff | s1_b_ff; end
         OP_ORI:  begin wr_rf = 1'b1; wr_val = s1_a_ff | s1_d_ff.imm; end
         OP_AND:  begin wr_rf = 1'b1; wr_idx = s1_d_ff.dest_reg[RW-1:0]; wr_val = s1_a_ff & s1_b_ff; end
         OP_ANDI: begin wr_rf = 1'b1; wr_val = s1_a_ff & s1_d_ff.imm; end
         OP_XOR:  begin wr_rf = 1'b1; wr_idx = s1_d_ff.dest_reg[RW-1:0]; wr_val = s1_a_ff ^ s1_b_ff; end
         OP_XORI: begin wr_rf = 1'b1; wr_val = s1_a_ff ^ s1_d_ff.imm; end
         OP_LDW: begin
            res.address_error = s1_bad_addr_ff;
            if (!s1_bad_addr_ff) begin
               wr_rf = 1'b1;
               wr_val = s1_fwd_ff ? s1_fwd_val_ff : ram_q;
               res.mem_word_index = 10'(s1_word_ff);
            end
         end
         OP_STW: begin
            res.address_error = s1_bad_addr_ff;
            if (!s1_bad_addr_ff) begin
               res.mem_write_valid = 1'b1;
               res.mem_write_value = s1_b_ff;
               res.mem_word_index  = 10'(s1_word_ff);
            end
         end
         OP_BZ:   if (s1_a_ff == '0) pc_in = pc_ff + s1_d_ff.imm;
         OP_BEQ:  if (s1_a_ff == s1_b_ff) pc_in = pc_ff + s1_d_ff.imm;
         OP_JR:   pc_in = s1_a_ff;
         OP_HALT: halt_in = 1'b1;
         default: res.invalid_opcode = s1_d_ff.bad_op;
      endcase
      wr_rf = wr_rf && s1_ff;
      res.next_pc = pc_in;
      res.halted = halt_in;
      res.reg_write_valid = wr_rf;
      res.reg_write_index = wr_rf ? 5'(wr_idx) : 5'd0;
      res.reg_write_value = wr_rf ? wr_val : '0;
   end

   // commit architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= '0;
         halt_ff <= 1'b0;
         rf_vld_ff <= '0;
      end else if (s1_ff) begin
         pc_ff <= pc_in;
         halt_ff <= halt_in;
         if (wr_rf) rf_vld_ff[wr_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_rf) rf_ff[wr_idx] <= wr_val;
      if (s1_ff) ob_ff[ow_ff] <= res;
   end

   // result queue pointers
   logic o_pop;
   assign o_pop = res_take && ocnt_ff != 2'd0;
   always_ff @(posedge clock) begin
      if (reset) begin
         ow_ff <= '0;
         or_ff <= '0;
         ocnt_ff <= '0;
      end else begin
         ow_ff <= ow_ff + 1'(s1_ff);
         or_ff <= or_ff + 1'(o_pop);
         ocnt_ff <= ocnt_ff + 2'(s1_ff) - 2'(o_pop);
      end
   end

   assign res_valid = (ocnt_ff != 2'd0);
   assign res_data  = ob_ff[or_ff];
endmodule

// ----- rtl/core/mlie_checker.sv -----
`timescale 1ns / 1ps
module mlie_checker (
   input logic        clock,
   input logic        reset,
   input logic        empty,
   input logic        pop,
   input logic        rsp_halted,
   input logic        rsp_reg_write_valid,
   input logic        rsp_mem_write_valid,
   input logic        rsp_invalid_opcode,
   input logic        rsp_address_error
);
   // a flagged opcode writes nothing
   a_bad_op: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_invalid_opcode |-> !rsp_reg_write_valid && !rsp_mem_write_valid)
      else $error("invalid opcode wrote state");
   // an address fault suppresses the access
   a_bad_addr: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_address_error |-> !rsp_mem_write_valid && !rsp_reg_write_valid)
      else $error("faulted access wrote state");
   // never a register and memory write in one beat
   a_one_write: assert property (@(posedge clock) disable iff (reset)
      !empty |-> !(rsp_reg_write_valid && rsp_mem_write_valid))
      else $error("double write");
   // halt flag sticks across consecutive beats
   a_halt: assert property (@(posedge clock) disable iff (reset)
      !empty && pop && rsp_halted ##1 !empty |-> rsp_halted)
      else $error("halt flag cleared");
endmodule

bind mips_lite_instruction_executor_core mlie_checker u_checker (
   .clock, .reset, .empty, .pop, .rsp_halted, .rsp_reg_write_valid,
   .rsp_mem_write_valid, .rsp_invalid_opcode, .rsp_address_error
);

// ----- tb/mips_lite_instruction_executor_core_tb.sv -----
`timescale 1ns / 1ps
module mips_lite_instruction_executor_core_tb;
   import mlie_pkg::*;

   localparam int MEM_WORDS = 1024;
   localparam int REG_COUNT = 32;

   typedef struct packed {
      logic [31:0] next_pc;
      logic        halted;
      logic        reg_write_valid;
      logic [4:0]  reg_write_index;
      logic [31:0] reg_write_value;
      logic        mem_write_valid;
      logic [9:0]  mem_word_index;
      logic [31:0] mem_write_value;
      logic        invalid_opcode;
      logic        address_error;
   } outcome_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic full;
   logic [4:0] req_action = '0;
   logic [4:0] req_src_reg = '0;
   logic [4:0] req_second_reg = '0;
   logic [4:0] req_dest_reg = '0;
   logic signed [15:0] req_immediate = '0;
   logic empty;
   logic pop = 1'b0;
   logic [31:0] rsp_next_pc;
   logic rsp_halted, rsp_reg_write_valid, rsp_mem_write_valid;
   logic [4:0] rsp_reg_write_index;
   logic signed [31:0] rsp_reg_write_value, rsp_mem_write_value;
   logic [9:0] rsp_mem_word_index;
   logic rsp_invalid_opcode, rsp_address_error;

   mips_lite_instruction_executor_core #(
      .MEM_WORDS(MEM_WORDS), .REG_COUNT(REG_COUNT)
   ) i_dut (.*);

   // shadow architectural state
   logic [31:0] shadow_regs [REG_COUNT];
   logic [31:0] shadow_mem [MEM_WORDS];
   logic [31:0] shadow_pc;
   logic        shadow_halt;

   outcome_t expected_beats [$];
   int  fail_count = 0;
   bit  long_hold = 1'b0;
   bit  idle_off = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   // execute one instruction on the shadow state
   function automatic outcome_t execute_instr(logic [4:0] op, logic [4:0] rs_f,
         logic [4:0] rt_f, logic [4:0] rd_f, logic [15:0] imm16);
      outcome_t o;
      logic [4:0] rs, rt, rd;
      logic [31:0] a, b, imm, addr, pc4;
      o = '0;
      rs = 5'(rs_f % REG_COUNT);
      rt = 5'(rt_f % REG_COUNT);
      rd = 5'(rd_f % REG_COUNT);
      imm = {{16{imm16[15]}}, imm16};
      a = shadow_regs[rs];
      b = shadow_regs[rt];
      pc4 = shadow_pc + PC_STEP;
      o.next_pc = pc4;
      case (op)
         OP_ADD:  begin o.reg_write_valid = 1; o.reg_write_index = rd; o.reg_write_value = a + b; end
         OP_ADDI: begin o.reg_write_valid = 1; o.reg_write_index = rt; o.reg_write_value = a + imm; end
         OP_SUB:  begin o.reg_write_valid = 1; o.reg_write_index = rd; o.reg_write_value = a - b; end
         OP_SUBI: begin o.reg_write_valid = 1; o.reg_write_index = rt; o.reg_write_value = a - imm; end
         OP_MUL:  begin o.reg_write_valid = 1; o.reg_write_index = rd; o.reg_write_value = a * b; end
         OP_MULI: begin o.reg_write_valid = 1; o.reg_write_index = rt; o.reg_write_value = a * imm; end
         OP_OR:   begin o.reg_write_valid = 1; o.reg_write_index = rd; o.reg_write_value = a | b; end
         OP_ORI:  begin o.reg_write_valid = 1; o.reg_write_index = rt; o.reg_write_value = a | imm; end
         OP_AND:  begin o.reg_write_valid = 1; o.reg_write_index = rd; o.reg_write_value = a & b; end
         OP_ANDI: begin o.reg_write_valid = 1; o.reg_write_index = rt; o.reg_write_value = a & imm; end
         OP_XOR:  begin o.reg_write_valid = 1; o.reg_write_index = rd; o.reg_write_value = a ^ b; end
         OP_XORI: begin o.reg_write_valid = 1; o.reg_write_index = rt; o.reg_write_value = a ^ imm; end
         OP_LDW, OP_STW: begin
            addr = a + imm;
            if (addr[31] || (addr >> 2) >= MEM_WORDS) begin
               o.address_error = 1;
            end else if (op == OP_LDW) begin
               o.mem_word_index = addr[11:2];
               o.reg_write_valid = 1;
               o.reg_write_index = rt;
               o.reg_write_value = shadow_mem[addr[11:2]];
            end else begin
               o.mem_word_index = addr[11:2];
               o.mem_write_valid = 1;
               o.mem_write_value = b;
               shadow_mem[addr[11:2]] = b;
            end
         end
         OP_BZ:   if (a == 0) o.next_pc = shadow_pc + imm;
         OP_BEQ:  if (a == b) o.next_pc = shadow_pc + imm;
         OP_JR:   o.next_pc = a;
         OP_HALT: shadow_halt = 1;
         default: o.invalid_opcode = 1;
      endcase
      if (o.reg_write_valid) shadow_regs[o.reg_write_index] = o.reg_write_value;
      shadow_pc = o.next_pc;
      o.halted = shadow_halt;
      return o;
   endfunction

   // send one instruction beat; record its outcome on acceptance
   task automatic send_instr(logic [4:0] op, logic [4:0] rs, logic [4:0] rt,
         logic [4:0] rd, logic [15:0] imm);
      while (!idle_off && $urandom_range(99) < 27) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_action <= op;
      req_src_reg <= rs;
      req_second_reg <= rt;
      req_dest_reg <= rd;
      req_immediate <= imm;
      @(posedge clock);
      while (full) @(posedge clock);
      expected_beats.push_back(execute_instr(op, rs, rt, rd, imm));
   endtask

   task automatic wait_drained();
      req_push <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // pop side: random stalls, long hold-off on request
   initial begin
      @(negedge reset);
      forever begin
         @(posedge clock);
         pop <= !long_hold && (idle_off || $urandom_range(99) >= 27);
      end
   end

   // check each accepted result beat
   initial begin
      outcome_t want;
      forever begin
         @(posedge clock);
         if (!reset && pop && !empty) begin
            if (expected_beats.size() == 0) begin
               $error("result beat with no expectation, pc %h", rsp_next_pc);
               fail_count++;
            end else begin
               want = expected_beats.pop_front();
               if (rsp_next_pc !== want.next_pc) begin
                  $error("next_pc exp %h got %h", want.next_pc, rsp_next_pc); fail_count++; end
               if (rsp_halted !== want.halted) begin
                  $error("halted exp %b got %b", want.halted, rsp_halted); fail_count++; end
               if (rsp_reg_write_valid !== want.reg_write_valid) begin
                  $error("reg_write_valid exp %b got %b", want.reg_write_valid,
                     rsp_reg_write_valid); fail_count++; end
               if (rsp_reg_write_index !== want.reg_write_index) begin
                  $error("reg_write_index exp %0d got %0d", want.reg_write_index,
                     rsp_reg_write_index); fail_count++; end
               if (rsp_reg_write_value !== want.reg_write_value) begin
                  $error("reg_write_value exp %h got %h", want.reg_write_value,
                     rsp_reg_write_value); fail_count++; end
               if (rsp_mem_write_valid !== want.mem_write_valid) begin
                  $error("mem_write_valid exp %b got %b", want.mem_write_valid,
                     rsp_mem_write_valid); fail_count++; end
               if (rsp_mem_word_index !== want.mem_word_index) begin
                  $error("mem_word_index exp %0d got %0d", want.mem_word_index,
                     rsp_mem_word_index); fail_count++; end
               if (rsp_mem_write_value !== want.mem_write_value) begin
                  $error("mem_write_value exp %h got %h", want.mem_write_value,
                     rsp_mem_write_value); fail_count++; end
               if (rsp_invalid_opcode !== want.invalid_opcode) begin
                  $error("invalid_opcode exp %b got %b", want.invalid_opcode,
                     rsp_invalid_opcode); fail_count++; end
               if (rsp_address_error !== want.address_error) begin
                  $error("address_error exp %b got %b", want.address_error,
                     rsp_address_error); fail_count++; end
            end
         end
      end
   end

   // directed: every opcode, extremes, branches, bad addresses, invalid opcodes
   task automatic test_directed();
      send_instr(OP_ADDI, 5'd0, 5'd1, 5'd0, 16'h7FFF);
      send_instr(OP_ADDI, 5'd0, 5'd2, 5'd0, 16'h8000);
      send_instr(OP_ADD, 5'd1, 5'd2, 5'd31, 16'h0);
      send_instr(OP_SUB, 5'd2, 5'd1, 5'd3, 16'h0);
      send_instr(OP_SUBI, 5'd31, 5'd4, 5'd0, 16'hFFFF);
      send_instr(OP_MUL, 5'd1, 5'd1, 5'd5, 16'h0);
      send_instr(OP_MULI, 5'd2, 5'd6, 5'd0, 16'h8000);
      send_instr(OP_OR, 5'd1, 5'd2, 5'd7, 16'h0);
      send_instr(OP_ORI, 5'd0, 5'd8, 5'd0, 16'h5A5A);
      send_instr(OP_AND, 5'd7, 5'd2, 5'd9, 16'h0);
      send_instr(OP_ANDI, 5'd31, 5'd10, 5'd0, 16'hF0F0);
      send_instr(OP_XOR, 5'd1, 5'd2, 5'd11, 16'h0);
      send_instr(OP_XORI, 5'd11, 5'd12, 5'd0, 16'hFFFF);
      send_instr(OP_STW, 5'd0, 5'd31, 5'd0, 16'd4092);   // last word
      send_instr(OP_LDW, 5'd0, 5'd13, 5'd0, 16'd4095);   // unaligned, last word
      send_instr(OP_STW, 5'd0, 5'd1, 5'd0, 16'h8000);    // negative address
      send_instr(OP_LDW, 5'd0, 5'd14, 5'd0, 16'd4096);   // beyond memory
      send_instr(OP_BZ, 5'd0, 5'd0, 5'd0, 16'hFFF0);     // taken, backward
      send_instr(OP_BZ, 5'd1, 5'd0, 5'd0, 16'h0100);     // not taken
      send_instr(OP_BEQ, 5'd0, 5'd0, 5'd0, 16'h0040);    // taken
      send_instr(OP_BEQ, 5'd1, 5'd2, 5'd0, 16'h0040);    // not taken
      send_instr(OP_JR, 5'd2, 5'd0, 5'd0, 16'h0);
      send_instr(5'd18, 5'd3, 5'd3, 5'd3, 16'h1234);
      send_instr(5'd31, 5'd31, 5'd31, 5'd31, 16'hFFFF);
      send_instr(OP_HALT, 5'd0, 5'd0, 5'd0, 16'h0);
   endtask

   // random instruction with a bias toward in-range memory access
   task automatic send_random();
      logic [4:0] op, rs;
      logic [15:0] imm;
      op = ($urandom_range(99) < 6) ? 5'($urandom_range(31, 18)) : 5'($urandom_range(17));
      rs = 5'($urandom);
      imm = 16'($urandom);
      if ((op == OP_LDW || op == OP_STW) && $urandom_range(3) != 0) begin
         rs = '0;
         imm = 16'($urandom_range(4095));
         if (shadow_regs[0] != 0) rs = 5'($urandom_range(31));
      end
      if (op == OP_HALT && $urandom_range(9) != 0) op = OP_ADDI;
      send_instr(op, rs, 5'($urandom), 5'($urandom), imm);
   endtask

   task automatic test_random(int count);
      repeat (count) send_random();
   endtask

   // hold the receiver off so the block fills and stalls its input
   task automatic test_backpressure();
      long_hold = 1'b1;
      fork
         begin
            repeat (200) @(posedge clock);
            long_hold = 1'b0;
         end
         repeat (60) send_random();
      join
   endtask

   task automatic test_no_idle();
      idle_off = 1'b1;
      test_random(250);
      idle_off = 1'b0;
   endtask

   initial begin
      for (int i = 0; i < REG_COUNT; i++) shadow_regs[i] = '0;
      for (int i = 0; i < MEM_WORDS; i++) shadow_mem[i] = '0;
      shadow_pc = '0;
      shadow_halt = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(500);
      wait_drained();
      test_backpressure();
      test_no_idle();
      test_random(600);
      wait_drained();
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
